// File: rtl/icr_pkg.sv
// types, widths and saturation helper shared by the collision resolver modules
package icr_pkg;

	localparam int VW   = 32;
	localparam int IMW  = 24;
	localparam int RW   = 17;
	localparam int NRMW = 16;
	localparam int PENW = 31;
	localparam int MW   = 36;
	localparam int KW   = 19;
	localparam int PW   = 55;
	localparam int PLW  = 28;
	localparam int NW   = PW + IMW;
	localparam int DW   = IMW + 2;
	localparam int QW   = 54;
	localparam int UW   = QW + 1 - 16;
	localparam int SATW = 48;

	typedef struct packed {
		logic signed [VW-1:0]   vel_a_x;
		logic signed [VW-1:0]   vel_a_y;
		logic signed [VW-1:0]   vel_b_x;
		logic signed [VW-1:0]   vel_b_y;
		logic [IMW-1:0]         inv_mass_a;
		logic [IMW-1:0]         inv_mass_b;
		logic [RW-1:0]          restitution_a;
		logic [RW-1:0]          restitution_b;
		logic signed [NRMW-1:0] normal_x;
		logic signed [NRMW-1:0] normal_y;
		logic [PENW-1:0]        penetration;
	} icr_in_t;

	typedef struct packed {
		logic signed [VW-1:0] new_vel_a_x;
		logic signed [VW-1:0] new_vel_a_y;
		logic signed [VW-1:0] new_vel_b_x;
		logic signed [VW-1:0] new_vel_b_y;
		logic signed [VW-1:0] move_a_x;
		logic signed [VW-1:0] move_a_y;
		logic signed [VW-1:0] move_b_x;
		logic signed [VW-1:0] move_b_y;
		logic                 impulse_applied;
	} icr_out_t;

	typedef struct packed {
		logic signed [VW-1:0]   vel_a_x;
		logic signed [VW-1:0]   vel_a_y;
		logic signed [VW-1:0]   vel_b_x;
		logic signed [VW-1:0]   vel_b_y;
		logic signed [NRMW-1:0] normal_x;
		logic signed [NRMW-1:0] normal_y;
		logic signed [VW-1:0]   move_a_x;
		logic signed [VW-1:0]   move_a_y;
		logic signed [VW-1:0]   move_b_x;
		logic signed [VW-1:0]   move_b_y;
		logic                   dyn_a;
		logic                   dyn_b;
		logic                   applied;
	} icr_side_t;

	function automatic logic signed [VW-1:0] sat32(input logic signed [SATW-1:0] x);
		logic signed [SATW-1:0] hi;
		logic signed [SATW-1:0] lo;
		hi = SATW'(33'sh0_7FFF_FFFF);
		lo = -SATW'(33'sh0_8000_0000);
		if (x > hi) begin
			return {1'b0, {(VW-1){1'b1}}};
		end else if (x < lo) begin
			return {1'b1, {(VW-1){1'b0}}};
		end else begin
			return x[VW-1:0];
		end
	endfunction

endpackage

// File: rtl/icr_front.sv
// front stages: closing speed, separation shift, impulse numerator and divisor
module icr_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_valid,
	input  icr_pkg::icr_in_t        in_data,
	output logic                    out_valid,
	output icr_pkg::icr_side_t      side,
	output logic [icr_pkg::NW-1:0]  num_a,
	output logic [icr_pkg::NW-1:0]  num_b,
	output logic [icr_pkg::DW-1:0]  den
);
	import icr_pkg::*;

	logic [6:0] v_q;

	icr_side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic signed [VW:0]       dvx_s1, dvy_s1;
	logic signed [SATW-1:0]   pnx_s1, pny_s1;
	logic [KW-1:0]            k_s1, k_s2, k_s3;
	logic [IMW-1:0]           ia_s1, ia_s2, ia_s3, ia_s4, ia_s5;
	logic [IMW-1:0]           ib_s1, ib_s2, ib_s3, ib_s4, ib_s5;
	logic signed [VW+NRMW:0]  dx_s2, dy_s2;
	logic [MW-1:0]            m_s3;
	logic [KW+18-1:0]         pkl_s4, pkh_s4;
	logic [PW-1:0]            p_s5;
	logic [PLW+IMW-1:0]       nal_s6, nbl_s6;
	logic [PW-PLW+IMW-1:0]    nah_s6, nbh_s6;
	logic [DW-1:0]            den_s6, den_s7;
	logic [NW-1:0]            na_s7, nb_s7;

	logic signed [SATW-1:0]   tx, ty;
	logic signed [VW+NRMW+1:0] d_sum, neg_d;
	icr_side_t                side_mv, side_ap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[5:0], in_valid};
		end
	end

	always_comb begin
		tx = (pnx_s1 + SATW'(8192)) >>> 14;
		ty = (pny_s1 + SATW'(8192)) >>> 14;
		side_mv = side_s1;
		if (side_s1.dyn_a) begin
			side_mv.move_a_x = sat32(-tx);
			side_mv.move_a_y = sat32(-ty);
		end else if (side_s1.dyn_b) begin
			side_mv.move_b_x = sat32(tx);
			side_mv.move_b_y = sat32(ty);
		end
	end

	always_comb begin
		d_sum = (VW+NRMW+2)'(dx_s2) + (VW+NRMW+2)'(dy_s2);
		neg_d = -d_sum;
		side_ap = side_s2;
		side_ap.applied = (side_s2.dyn_a | side_s2.dyn_b) && (d_sum <= 0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.vel_a_x  <= in_data.vel_a_x;
			side_s1.vel_a_y  <= in_data.vel_a_y;
			side_s1.vel_b_x  <= in_data.vel_b_x;
			side_s1.vel_b_y  <= in_data.vel_b_y;
			side_s1.normal_x <= in_data.normal_x;
			side_s1.normal_y <= in_data.normal_y;
			side_s1.move_a_x <= '0;
			side_s1.move_a_y <= '0;
			side_s1.move_b_x <= '0;
			side_s1.move_b_y <= '0;
			side_s1.dyn_a    <= (in_data.inv_mass_a != '0);
			side_s1.dyn_b    <= (in_data.inv_mass_b != '0);
			side_s1.applied  <= 1'b0;
			dvx_s1 <= (VW+1)'(in_data.vel_b_x) - (VW+1)'(in_data.vel_a_x);
			dvy_s1 <= (VW+1)'(in_data.vel_b_y) - (VW+1)'(in_data.vel_a_y);
			pnx_s1 <= $signed({1'b0, in_data.penetration}) * in_data.normal_x;
			pny_s1 <= $signed({1'b0, in_data.penetration}) * in_data.normal_y;
			k_s1   <= KW'(131072) + KW'(in_data.restitution_a) + KW'(in_data.restitution_b);
			ia_s1  <= in_data.inv_mass_a;
			ib_s1  <= in_data.inv_mass_b;

			side_s2 <= side_mv;
			dx_s2   <= dvx_s1 * side_s1.normal_x;
			dy_s2   <= dvy_s1 * side_s1.normal_y;
			k_s2    <= k_s1;
			ia_s2   <= ia_s1;
			ib_s2   <= ib_s1;

			side_s3 <= side_ap;
			m_s3    <= side_ap.applied ? MW'((neg_d + (VW+NRMW+2)'(8192)) >>> 14) : '0;
			k_s3    <= k_s2;
			ia_s3   <= ia_s2;
			ib_s3   <= ib_s2;

			side_s4 <= side_s3;
			pkl_s4  <= k_s3 * m_s3[17:0];
			pkh_s4  <= k_s3 * m_s3[MW-1:18];
			ia_s4   <= ia_s3;
			ib_s4   <= ib_s3;

			side_s5 <= side_s4;
			p_s5    <= {pkh_s4, 18'b0} + PW'(pkl_s4);
			ia_s5   <= ia_s4;
			ib_s5   <= ib_s4;

			side_s6 <= side_s5;
			nal_s6  <= p_s5[PLW-1:0] * ia_s5;
			nah_s6  <= p_s5[PW-1:PLW] * ia_s5;
			nbl_s6  <= p_s5[PLW-1:0] * ib_s5;
			nbh_s6  <= p_s5[PW-1:PLW] * ib_s5;
			den_s6  <= {(IMW+1)'(ia_s5) + (IMW+1)'(ib_s5), 1'b0};

			side_s7 <= side_s6;
			na_s7   <= {nah_s6, {PLW{1'b0}}} + NW'(nal_s6);
			nb_s7   <= {nbh_s6, {PLW{1'b0}}} + NW'(nbl_s6);
			den_s7  <= den_s6;
		end
	end

	assign out_valid = v_q[6];
	assign side      = side_s7;
	assign num_a     = na_s7;
	assign num_b     = nb_s7;
	assign den       = den_s7;

endmodule

// File: rtl/icr_div.sv
// pipelined restoring divider, one quotient bit per stage, two numerators over one divisor
module icr_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_valid,
	input  icr_pkg::icr_side_t      in_side,
	input  logic [icr_pkg::NW-1:0]  num_a,
	input  logic [icr_pkg::NW-1:0]  num_b,
	input  logic [icr_pkg::DW-1:0]  den,
	output logic                    out_valid,
	output icr_pkg::icr_side_t      out_side,
	output logic [icr_pkg::QW-1:0]  quo_a,
	output logic [icr_pkg::QW-1:0]  quo_b
);
	import icr_pkg::*;

	logic [QW-1:0]  v_st;
	icr_side_t      side_st [QW];
	logic [DW-1:0]  den_st  [QW];
	logic [DW-1:0]  ra_st   [QW];
	logic [DW-1:0]  rb_st   [QW];
	logic [QW-1:0]  la_st   [QW];
	logic [QW-1:0]  lb_st   [QW];
	logic [QW-1:0]  qa_st   [QW];
	logic [QW-1:0]  qb_st   [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic            v_src;
		icr_side_t       side_src;
		logic [DW-1:0]   den_src, ra_src, rb_src;
		logic [QW-1:0]   la_src, lb_src, qa_src, qb_src;
		logic [DW:0]     ca, cb;
		logic            ta, tb;

		if (j == 0) begin : g_first
			assign v_src    = in_valid;
			assign side_src = in_side;
			assign den_src  = den;
			assign ra_src   = DW'(num_a[NW-1:QW]);
			assign rb_src   = DW'(num_b[NW-1:QW]);
			assign la_src   = num_a[QW-1:0];
			assign lb_src   = num_b[QW-1:0];
			assign qa_src   = '0;
			assign qb_src   = '0;
		end else begin : g_next
			assign v_src    = v_st[j-1];
			assign side_src = side_st[j-1];
			assign den_src  = den_st[j-1];
			assign ra_src   = ra_st[j-1];
			assign rb_src   = rb_st[j-1];
			assign la_src   = la_st[j-1];
			assign lb_src   = lb_st[j-1];
			assign qa_src   = qa_st[j-1];
			assign qb_src   = qb_st[j-1];
		end

		assign ca = {ra_src, la_src[QW-1-j]};
		assign cb = {rb_src, lb_src[QW-1-j]};
		assign ta = (ca >= {1'b0, den_src});
		assign tb = (cb >= {1'b0, den_src});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_st[j] <= 1'b0;
			end else if (adv) begin
				v_st[j] <= v_src;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_st[j] <= side_src;
				den_st[j]  <= den_src;
				la_st[j]   <= la_src;
				lb_st[j]   <= lb_src;
				ra_st[j]   <= ta ? DW'(ca - {1'b0, den_src}) : DW'(ca);
				rb_st[j]   <= tb ? DW'(cb - {1'b0, den_src}) : DW'(cb);
				qa_st[j]   <= {qa_src[QW-2:0], ta};
				qb_st[j]   <= {qb_src[QW-2:0], tb};
			end
		end
	end

	assign out_valid = v_st[QW-1];
	assign out_side  = side_st[QW-1];
	assign quo_a     = qa_st[QW-1];
	assign quo_b     = qb_st[QW-1];

endmodule

// File: rtl/icr_back.sv
// back stages: impulse rounding, projection on the normal and saturated velocity update
module icr_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_valid,
	input  icr_pkg::icr_side_t      in_side,
	input  logic [icr_pkg::QW-1:0]  quo_a,
	input  logic [icr_pkg::QW-1:0]  quo_b,
	output logic                    out_valid,
	output icr_pkg::icr_out_t       out_data
);
	import icr_pkg::*;

	localparam int PRW = UW + 1 + NRMW;

	logic [2:0]              v_q;
	icr_side_t               side_s1, side_s2;
	logic [UW-1:0]           ua_s1, ub_s1;
	logic signed [PRW-1:0]   pax_s2, pay_s2, pbx_s2, pby_s2;
	icr_out_t                res_s3;

	logic signed [PRW-1:0]   dax, day, dbx, dby;
	logic                    upd_a, upd_b;
	icr_out_t                res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[1:0], in_valid};
		end
	end

	always_comb begin
		dax   = (pax_s2 + PRW'(8192)) >>> 14;
		day   = (pay_s2 + PRW'(8192)) >>> 14;
		dbx   = (pbx_s2 + PRW'(8192)) >>> 14;
		dby   = (pby_s2 + PRW'(8192)) >>> 14;
		upd_a = side_s2.applied & side_s2.dyn_a;
		upd_b = side_s2.applied & side_s2.dyn_b;
		res.new_vel_a_x = upd_a ? sat32(SATW'(side_s2.vel_a_x) - SATW'(dax)) : side_s2.vel_a_x;
		res.new_vel_a_y = upd_a ? sat32(SATW'(side_s2.vel_a_y) - SATW'(day)) : side_s2.vel_a_y;
		res.new_vel_b_x = upd_b ? sat32(SATW'(side_s2.vel_b_x) + SATW'(dbx)) : side_s2.vel_b_x;
		res.new_vel_b_y = upd_b ? sat32(SATW'(side_s2.vel_b_y) + SATW'(dby)) : side_s2.vel_b_y;
		res.move_a_x        = side_s2.move_a_x;
		res.move_a_y        = side_s2.move_a_y;
		res.move_b_x        = side_s2.move_b_x;
		res.move_b_y        = side_s2.move_b_y;
		res.impulse_applied = side_s2.applied;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= in_side;
			ua_s1   <= UW'(((QW+1)'(quo_a) + (QW+1)'(32768)) >> 16);
			ub_s1   <= UW'(((QW+1)'(quo_b) + (QW+1)'(32768)) >> 16);

			side_s2 <= side_s1;
			pax_s2  <= $signed({1'b0, ua_s1}) * side_s1.normal_x;
			pay_s2  <= $signed({1'b0, ua_s1}) * side_s1.normal_y;
			pbx_s2  <= $signed({1'b0, ub_s1}) * side_s1.normal_x;
			pby_s2  <= $signed({1'b0, ub_s1}) * side_s1.normal_y;

			res_s3  <= res;
		end
	end

	assign out_valid = v_q[2];
	assign out_data  = res_s3;

endmodule

// File: rtl/impulse_collision_resolver_2d_core.sv
// top level of the 2d impulse collision resolver pipeline
//
//  channel  | valid         | stall         | payload
//  item     | item_valid    | item_stall    | item   (icr_in_t)
//  result   | result_valid  | result_stall  | result (icr_out_t)
//
// one contact enters per cycle while no held result stalls the pipeline
// each contact passes the 7 front stages, the 54-stage quotient pipeline and 3 back stages
// reset clears only the valid bits of every stage
// a held result freezes the whole pipeline; item_stall follows that hold
module impulse_collision_resolver_2d_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  icr_pkg::icr_in_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output icr_pkg::icr_out_t  result
);
	import icr_pkg::*;

	logic           adv;
	logic           f_valid, d_valid;
	icr_side_t      f_side, d_side;
	logic [NW-1:0]  f_num_a, f_num_b;
	logic [DW-1:0]  f_den;
	logic [QW-1:0]  d_quo_a, d_quo_b;

	assign adv        = !(result_valid && result_stall);
	assign item_stall = !adv;

	icr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (item_valid),
		.in_data   (item),
		.out_valid (f_valid),
		.side      (f_side),
		.num_a     (f_num_a),
		.num_b     (f_num_b),
		.den       (f_den)
	);

	icr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (f_valid),
		.in_side   (f_side),
		.num_a     (f_num_a),
		.num_b     (f_num_b),
		.den       (f_den),
		.out_valid (d_valid),
		.out_side  (d_side),
		.quo_a     (d_quo_a),
		.quo_b     (d_quo_b)
	);

	icr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (d_valid),
		.in_side   (d_side),
		.quo_a     (d_quo_a),
		.quo_b     (d_quo_b),
		.out_valid (result_valid),
		.out_data  (result)
	);

endmodule

// File: rtl/icr_chk.sv
// port checker for the collision resolver and its bind
module icr_chk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_stall,
	input  icr_pkg::icr_out_t  result,
	input  logic               result_valid,
	input  logic               result_stall
);
	import icr_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("held result changed");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item stalled without a held result");

	a_one_mover: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.move_a_x != '0 || result.move_a_y != '0)
		|-> result.move_b_x == '0 && result.move_b_y == '0)
		else $error("both bodies moved");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(result_valid) |-> $past(!result_stall))
		else $error("result dropped without transfer");

endmodule

bind impulse_collision_resolver_2d_core icr_chk u_icr_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result       (result),
	.result_valid (result_valid),
	.result_stall (result_stall)
);

// File: tb/testbench.sv
// testbench for the 2d impulse collision resolver: directed table, random contacts, bit-exact predictor
`timescale 1ns / 100ps

module testbench;
	import icr_pkg::*;

	typedef struct {
		icr_in_t  contact;
		bit       typed;
		icr_out_t outcome;
	} row_t;

	logic     clk;
	logic     arst_n;
	logic     item_valid;
	logic     item_stall;
	icr_in_t  item;
	logic     result_valid;
	logic     result_stall;
	icr_out_t result;

	icr_out_t pending_results[$];
	row_t     rows[$];
	int       mismatches;
	bit       calm;

	impulse_collision_resolver_2d_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #6 clk = ~clk;

	function automatic longint rnd_shift(longint x, int s);
		return (x + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] clip(longint x);
		if (x > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (x < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return x[31:0];
	endfunction

	function automatic longint unsigned impulse_share(longint unsigned p, longint unsigned w,
			longint unsigned s);
		longint unsigned s2, q, r, wide;
		s2 = 2 * s;
		q = p / s2;
		r = p % s2;
		wide = q * w + (r * w) / s2;
		return (wide + 32768) >> 16;
	endfunction

	function automatic icr_out_t resolve_contact(icr_in_t c);
		icr_out_t o;
		longint vax, vay, vbx, vby, nx, ny, pen, tx, ty, d, u;
		longint unsigned ia, ib, m, k, p, s;
		logic applied;
		vax = longint'(c.vel_a_x); vay = longint'(c.vel_a_y);
		vbx = longint'(c.vel_b_x); vby = longint'(c.vel_b_y);
		nx = longint'(c.normal_x); ny = longint'(c.normal_y);
		pen = longint'(c.penetration);
		ia = 64'(c.inv_mass_a); ib = 64'(c.inv_mass_b);
		applied = 1'b0;
		o = '0;
		if (ia != 0 || ib != 0) begin
			tx = rnd_shift(pen * nx, 14);
			ty = rnd_shift(pen * ny, 14);
			if (ia != 0) begin
				o.move_a_x = clip(-tx);
				o.move_a_y = clip(-ty);
			end else begin
				o.move_b_x = clip(tx);
				o.move_b_y = clip(ty);
			end
			d = (vbx - vax) * nx + (vby - vay) * ny;
			if (d <= 0) begin
				m = rnd_shift(-d, 14);
				k = 131072 + longint'(c.restitution_a) + longint'(c.restitution_b);
				p = k * m;
				s = ia + ib;
				applied = 1'b1;
				if (ia != 0) begin
					u = impulse_share(p, ia, s);
					vax -= rnd_shift(u * nx, 14);
					vay -= rnd_shift(u * ny, 14);
				end
				if (ib != 0) begin
					u = impulse_share(p, ib, s);
					vbx += rnd_shift(u * nx, 14);
					vby += rnd_shift(u * ny, 14);
				end
			end
		end
		o.new_vel_a_x = clip(vax);
		o.new_vel_a_y = clip(vay);
		o.new_vel_b_x = clip(vbx);
		o.new_vel_b_y = clip(vby);
		o.impulse_applied = applied;
		return o;
	endfunction

	function automatic logic signed [31:0] pick_vel();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 255)
				: 32'sh8000_0000 + $urandom_range(0, 255);
			default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
		endcase
	endfunction

	function automatic logic [23:0] pick_mass();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 24'($urandom);
			2: return 24'hFF_FFFF;
			default: return 24'($urandom_range(1, 24'h04_0000));
		endcase
	endfunction

	function automatic logic [16:0] pick_rest();
		if ($urandom_range(0, 9) == 0) begin
			return 17'($urandom);
		end
		return 17'($urandom_range(0, 65536));
	endfunction

	function automatic icr_in_t gen_contact();
		icr_in_t c;
		c.vel_a_x = pick_vel();
		c.vel_a_y = pick_vel();
		c.vel_b_x = pick_vel();
		c.vel_b_y = pick_vel();
		c.inv_mass_a = pick_mass();
		c.inv_mass_b = pick_mass();
		c.restitution_a = pick_rest();
		c.restitution_b = pick_rest();
		if ($urandom_range(0, 9) == 0) begin
			c.normal_x = 16'($urandom);
			c.normal_y = 16'($urandom);
		end else begin
			c.normal_x = 16'($signed($urandom_range(0, 32768)) - 16384);
			c.normal_y = 16'($signed($urandom_range(0, 32768)) - 16384);
		end
		c.penetration = 31'($urandom_range(0, 3) == 0 ? $urandom
			: $urandom_range(0, 32'h0004_0000));
		return c;
	endfunction

	function automatic icr_in_t contact(longint vax, longint vay, longint vbx, longint vby,
			longint ia, longint ib, longint ra, longint rb, longint nx, longint ny, longint pen);
		icr_in_t c;
		c = '{vel_a_x: 32'(vax), vel_a_y: 32'(vay), vel_b_x: 32'(vbx), vel_b_y: 32'(vby),
			inv_mass_a: 24'(ia), inv_mass_b: 24'(ib), restitution_a: 17'(ra),
			restitution_b: 17'(rb), normal_x: 16'(nx), normal_y: 16'(ny),
			penetration: 31'(pen)};
		return c;
	endfunction

	function automatic icr_out_t outcome(longint vax, longint vay, longint vbx, longint vby,
			longint max, longint may, longint mbx, longint mby, bit hit);
		icr_out_t o;
		o = '{new_vel_a_x: 32'(vax), new_vel_a_y: 32'(vay), new_vel_b_x: 32'(vbx),
			new_vel_b_y: 32'(vby), move_a_x: 32'(max), move_a_y: 32'(may),
			move_b_x: 32'(mbx), move_b_y: 32'(mby), impulse_applied: hit};
		return o;
	endfunction

	task automatic add_row(icr_in_t c, bit typed, icr_out_t o);
		rows.push_back('{contact: c, typed: typed, outcome: o});
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch %s: expected %0d actual %0d", name, want, got);
			end
		end
	endtask

	// result side: compare each transfer and decide the next stall
	always @(posedge clk) begin
		icr_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result transfer");
				end
			end else begin
				want = pending_results.pop_front();
				check_field("new_vel_a_x", longint'(want.new_vel_a_x),
					longint'(result.new_vel_a_x));
				check_field("new_vel_a_y", longint'(want.new_vel_a_y),
					longint'(result.new_vel_a_y));
				check_field("new_vel_b_x", longint'(want.new_vel_b_x),
					longint'(result.new_vel_b_x));
				check_field("new_vel_b_y", longint'(want.new_vel_b_y),
					longint'(result.new_vel_b_y));
				check_field("move_a_x", longint'(want.move_a_x), longint'(result.move_a_x));
				check_field("move_a_y", longint'(want.move_a_y), longint'(result.move_a_y));
				check_field("move_b_x", longint'(want.move_b_x), longint'(result.move_b_x));
				check_field("move_b_y", longint'(want.move_b_y), longint'(result.move_b_y));
				check_field("impulse_applied", longint'(want.impulse_applied),
					longint'(result.impulse_applied));
			end
		end
		result_stall <= !calm && $urandom_range(0, 99) < 36;
	end

	task automatic send_contact(icr_in_t c, icr_out_t want);
		while (!calm && $urandom_range(0, 99) < 36) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= c;
		do @(posedge clk); while (item_stall);
		pending_results.push_back(want);
	endtask

	initial begin
		int n;
		clk = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		mismatches = 0;
		calm = 1'b0;

		// both static: pass through
		add_row(contact(32'sh7FFF_FFFF, -32'sh8000_0000, 5, -7, 0, 0, 65536, 0, 16384, 0,
			31'h7FFF_FFFF), 1,
			outcome(32'sh7FFF_FFFF, -32'sh8000_0000, 5, -7, 0, 0, 0, 0, 0));
		// separating, a moves back by the full penetration
		add_row(contact(0, 0, 65536, 0, 65536, 65536, 0, 0, 16384, 0, 1000), 1,
			outcome(0, 0, 65536, 0, -1000, 0, 0, 0, 0));
		// separating, only b dynamic so b moves
		add_row(contact(0, 0, 0, 65536, 0, 65536, 0, 0, 0, 16384, 777), 1,
			outcome(0, 0, 0, 65536, 0, 0, 0, 777, 0));
		// zero closing speed
		add_row(contact(100, 200, 100, 200, 65536, 65536, 65536, 65536, 16384, 0, 0), 1,
			outcome(100, 200, 100, 200, 0, 0, 0, 0, 1));
		// extreme penetration drives the shift to the limit of the signed 32-bit range
		add_row(contact(0, 0, 0, 0, 1, 0, 0, 0, -16384, 16384, 31'h7FFF_FFFF), 0, '0);
		add_row(contact(0, 0, 0, 0, 0, 1, 0, 0, -16384, -16384, 31'h7FFF_FFFF), 0, '0);
		// head-on, elastic and inelastic
		add_row(contact(65536, 0, -65536, 0, 65536, 65536, 65536, 65536, 16384, 0, 10), 0, '0);
		add_row(contact(65536, 0, -65536, 0, 65536, 65536, 0, 0, 16384, 0, 10), 0, '0);
		add_row(contact(65536, 0, 0, 0, 65536, 0, 65536, 0, 16384, 0, 10), 0, '0);
		add_row(contact(0, 0, -65536, -65536, 0, 24'hFF_FFFF, 0, 65536, 11585, 11585, 5), 0, '0);
		// velocity overflow
		add_row(contact(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000, -32'sh8000_0000,
			24'hFF_FFFF, 1, 17'h1_FFFF, 17'h1_FFFF, 16384, 16384, 0), 0, '0);
		add_row(contact(-32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000,
			1, 24'hFF_FFFF, 17'h1_FFFF, 0, -32768, 32767, 12345), 0, '0);
		// out of range normal
		add_row(contact(1000, -3000, -500, 4000, 300, 900, 40000, 20000, 32767, -32768,
			65536), 0, '0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_contact(rows[i].contact, rows[i].typed ? rows[i].outcome
				: resolve_contact(rows[i].contact));
		end
		for (n = 0; n < 1650; n++) begin
			icr_in_t c;
			calm = n >= 700 && n < 1000;
			c = gen_contact();
			send_contact(c, resolve_contact(c));
		end
		calm = 1'b0;
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("testbench: errors");
		$finish;
	end

endmodule
